FILE: sv/accumulator_vm_execute_unit_top_defines.svh
// Assertion macros shared by the execute unit
`ifndef ACCUMULATOR_VM_EXECUTE_UNIT_TOP_DEFINES_SVH
`define ACCUMULATOR_VM_EXECUTE_UNIT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define AVM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AVM_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AVM_ASSERT(label, clk, rst_n, prop, msg)
`define AVM_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: sv/avm_pkg.sv
package avm_pkg;
    localparam int NUM_REGS    = 8;
    localparam int MEM_DEPTH   = 4096;
    localparam int STACK_DEPTH = 256;
    localparam int REG_AW  = $clog2(NUM_REGS);
    localparam int MEM_AW  = $clog2(MEM_DEPTH);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int STK_LW  = $clog2(STACK_DEPTH + 1);

    localparam logic [REG_AW-1:0] R_ACC = REG_AW'(0);
    localparam logic [REG_AW-1:0] R_DAT = REG_AW'(1);
    localparam logic [REG_AW-1:0] R_MAR = REG_AW'(2);
    localparam logic [REG_AW-1:0] R_MDR = REG_AW'(3);
    localparam logic [REG_AW-1:0] R_MCH = REG_AW'(4);
    localparam logic [REG_AW-1:0] R_IP  = REG_AW'(5);
    localparam logic [REG_AW-1:0] R_CSP = REG_AW'(6);

    localparam logic [63:0] CH_MEM = 64'd0;
    localparam logic [63:0] CH_INP = 64'd1;
    localparam logic [63:0] CH_OUT = 64'd2;
    localparam logic [63:0] CH_CST = 64'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_REG   = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_CHAN  = 3'd3;
    localparam logic [2:0] ST_OVER  = 3'd4;
    localparam logic [2:0] ST_UNDER = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_IO    = 3'd7;

    localparam logic [4:0] OP_PLACE = 5'd0;
    localparam logic [4:0] OP_MOVE  = 5'd1;
    localparam logic [4:0] OP_STORE = 5'd2;
    localparam logic [4:0] OP_LOAD  = 5'd3;
    localparam logic [4:0] OP_JMP   = 5'd4;
    localparam logic [4:0] OP_JSET  = 5'd5;
    localparam logic [4:0] OP_JCLR  = 5'd6;
    localparam logic [4:0] OP_ADD   = 5'd7;
    localparam logic [4:0] OP_SUB   = 5'd8;
    localparam logic [4:0] OP_NOT   = 5'd9;
    localparam logic [4:0] OP_INC   = 5'd10;
    localparam logic [4:0] OP_DEC   = 5'd11;
    localparam logic [4:0] OP_MUL   = 5'd12;
    localparam logic [4:0] OP_DIV   = 5'd13;
    localparam logic [4:0] OP_AND   = 5'd14;
    localparam logic [4:0] OP_OR    = 5'd15;
    localparam logic [4:0] OP_XOR   = 5'd16;
    localparam logic [4:0] OP_SHL   = 5'd17;
    localparam logic [4:0] OP_SHR   = 5'd18;
    localparam logic [4:0] OP_GT    = 5'd19;
    localparam logic [4:0] OP_LT    = 5'd20;
    localparam logic [4:0] OP_GE    = 5'd21;
    localparam logic [4:0] OP_LE    = 5'd22;
    localparam logic [4:0] OP_EQ    = 5'd23;
    localparam logic [4:0] OP_NE    = 5'd24;
    localparam logic [4:0] OP_CALL  = 5'd25;
    localparam logic [4:0] OP_RET   = 5'd26;

    typedef struct packed {
        logic [4:0]  func;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } t_instr;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] next_pointer;
        logic [63:0] acc_value;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the instruction
        logic decode;    // read operands, start memory read / multiply / divide
        logic mul_step;  // accumulate one partial product
        logic div_step;  // one quotient bit
        logic commit;    // write back
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic mul_last;
        logic div_last;
    } t_sts;
endpackage

FILE: sv/avm_if.sv
interface avm_instr_if;
    import avm_pkg::*;
    logic   valid;
    logic   ready;
    t_instr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface avm_result_if;
    import avm_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/accumulator_vm_execute_unit_top.sv
// channel    dir  payload
// i_instr    in   func, operand_a, operand_b
// o_result   out  status, next_pointer, acc_value
// Multiply sums 16-bit partial products over four steps; divide produces
// one quotient bit a cycle.
// The next transaction is taken once the unit is back in idle and the last
// result has gone, or goes in the same cycle; a held result stalls the input.
// Reset: synchronous, active low; registers cleared, stack pointer all ones.
`include "accumulator_vm_execute_unit_top_defines.svh"
module accumulator_vm_execute_unit_top
    import avm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    avm_instr_if.sink    i_instr,
    avm_result_if.source o_result
);
    t_cmd    cmd;
    t_sts    sts;
    t_result res;
    logic    out_valid;

    avm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_instr.valid),
        .o_in_ready  (i_instr.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    avm_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (i_instr.data),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (res)
    );

    assign o_result.valid = out_valid;
    assign o_result.data  = res;

    `AVM_ASSERT(a_valid_holds, i_clk, i_rst_n, (o_result.valid && !o_result.ready) |=> o_result.valid, "result dropped")
    `AVM_ASSERT(a_data_holds, i_clk, i_rst_n, (o_result.valid && !o_result.ready) |=> $stable(o_result.data), "result changed")
    `AVM_ASSERT_NR(a_no_valid_in_reset, i_clk, !i_rst_n |=> !o_result.valid, "valid after reset")
endmodule

FILE: sv/avm_ctrl.sv
`include "accumulator_vm_execute_unit_top_defines.svh"
module avm_ctrl
    import avm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // a new transaction is taken in idle, once the last result has gone or is taken in the same cycle
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.is_mul) begin
                    n_state = S_MUL;
                end else if (i_sts.is_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) n_state = S_COMMIT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `AVM_ASSERT(a_commit_from_idle_path, i_clk, i_rst_n, o_cmd.commit |=> (r_state == S_IDLE && r_out_valid), "commit did not raise result")
    `AVM_ASSERT(a_capture_then_decode, i_clk, i_rst_n, o_cmd.capture |=> o_cmd.decode, "decode did not follow capture")
    `AVM_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !o_cmd.capture, "capture with result pending")
endmodule

FILE: sv/avm_datapath.sv
`include "accumulator_vm_execute_unit_top_defines.svh"
module avm_datapath
    import avm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_instr  i_instr,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output t_result o_result
);
    logic [63:0] r_regs [NUM_REGS];
    logic [63:0] r_mem [MEM_DEPTH];
    logic [63:0] r_stk [STACK_DEPTH];
    logic [STK_LW-1:0] r_stk_len;

    t_instr      r_ins;
    logic [63:0] r_mem_q, r_stk_q;
    logic [63:0] r_acc_new;
    logic [2:0]  r_st;

    // multiplier: 16 bits of multiplier per step, four steps
    logic [63:0] r_mul_acc, r_mul_a, r_mul_b;
    logic [1:0]  r_mul_cnt;
    // restoring divider: one quotient bit per step
    logic [63:0] r_quo, r_rem, r_dvs;
    logic [5:0]  r_div_cnt;

    logic [63:0] acc, dat, mar, mch, csp, ip;
    assign acc = r_regs[R_ACC];
    assign dat = r_regs[R_DAT];
    assign mar = r_regs[R_MAR];
    assign mch = r_regs[R_MCH];
    assign csp = r_regs[R_CSP];
    assign ip  = r_regs[R_IP];

    logic a_reg_ok, b_reg_ok, mar_mem_ok, mar_stk_ok, csp_stk_ok;
    assign a_reg_ok   = r_ins.operand_a < 64'(NUM_REGS);
    assign b_reg_ok   = r_ins.operand_b < 64'(NUM_REGS);
    assign mar_mem_ok = mar < 64'(MEM_DEPTH);
    assign mar_stk_ok = mar < 64'(STACK_DEPTH);
    assign csp_stk_ok = csp < 64'(STACK_DEPTH);

    assign o_sts.is_mul   = r_ins.func == OP_MUL;
    assign o_sts.is_div   = (r_ins.func == OP_DIV) && (dat != 64'd0);
    assign o_sts.mul_last = r_mul_cnt == 2'd3;
    assign o_sts.div_last = r_div_cnt == 6'd63;

    // combinational part of the ALU, valid during decode
    logic [63:0] alu;
    logic [2:0]  st;
    always_comb begin
        alu = acc;
        st  = ST_OK;
        case (r_ins.func)
            OP_PLACE: if (!b_reg_ok) st = ST_REG;
            OP_MOVE:  if (!b_reg_ok || !a_reg_ok) st = ST_REG;
            OP_STORE, OP_LOAD: begin
                if (mch == CH_MEM) begin
                    if (!mar_mem_ok) st = ST_ADDR;
                end else if (mch == CH_CST) begin
                    if (!mar_stk_ok) st = ST_ADDR;
                end else if (mch == CH_INP || mch == CH_OUT) begin
                    st = ST_IO;
                end else begin
                    st = ST_CHAN;
                end
            end
            OP_JMP, OP_JSET, OP_JCLR: ;
            OP_ADD:   alu = acc + dat;
            OP_SUB:   alu = acc - dat;
            OP_NOT:   alu = ~acc;
            OP_INC:   alu = acc + 64'd1;
            OP_DEC:   alu = acc - 64'd1;
            OP_MUL:   ;
            OP_DIV:   if (dat == 64'd0) st = ST_DIV;
            OP_AND:   alu = acc & dat;
            OP_OR:    alu = acc | dat;
            OP_XOR:   alu = acc ^ dat;
            OP_SHL:   alu = (dat >= 64'd64) ? 64'd0 : acc << dat[5:0];
            OP_SHR:   alu = (dat >= 64'd64) ? 64'd0 : acc >> dat[5:0];
            OP_GT:    alu = {63'd0, acc > dat};
            OP_LT:    alu = {63'd0, acc < dat};
            OP_GE:    alu = {63'd0, acc >= dat};
            OP_LE:    alu = {63'd0, acc <= dat};
            OP_EQ:    alu = {63'd0, acc == dat};
            OP_NE:    alu = {63'd0, acc != dat};
            OP_CALL:  if (r_stk_len >= STK_LW'(STACK_DEPTH)) st = ST_OVER;
            OP_RET: begin
                if (csp == '1) st = ST_UNDER;
                else if (!csp_stk_ok) st = ST_ADDR;
            end
            default:  st = ST_IO;
        endcase
    end

    logic [63:0] rem_sh, rem_sub;
    assign rem_sh  = {r_rem[62:0], r_quo[63]};
    assign rem_sub = rem_sh - r_dvs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_ins <= i_instr;
        if (i_cmd.decode) begin
            r_st      <= st;
            r_acc_new <= alu;
            r_mem_q   <= r_mem[mar[MEM_AW-1:0]];
            r_stk_q   <= (r_ins.func == OP_RET) ? r_stk[csp[STK_AW-1:0]]
                                                : r_stk[mar[STK_AW-1:0]];
            r_mul_acc <= '0;
            r_mul_a   <= acc;
            r_mul_b   <= dat;
            r_mul_cnt <= '0;
            r_quo     <= acc;
            r_rem     <= '0;
            r_dvs     <= dat;
            r_div_cnt <= '0;
        end
        if (i_cmd.mul_step) begin
            r_mul_acc <= r_mul_acc + 64'(r_mul_a * r_mul_b[15:0]);
            r_mul_a   <= r_mul_a << 16;
            r_mul_b   <= r_mul_b >> 16;
            r_mul_cnt <= r_mul_cnt + 2'd1;
            if (r_mul_cnt == 2'd3)
                r_acc_new <= r_mul_acc + 64'(r_mul_a * r_mul_b[15:0]);
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 6'd1;
            if ((r_rem[63] == 1'b0) && (rem_sh >= r_dvs) || r_rem[63]) begin
                r_rem <= rem_sub;
                r_quo <= {r_quo[62:0], 1'b1};
                if (r_div_cnt == 6'd63) r_acc_new <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[62:0], 1'b0};
                if (r_div_cnt == 6'd63) r_acc_new <= {r_quo[62:0], 1'b0};
            end
        end
        if (i_cmd.commit && r_st == ST_OK) begin
            if (r_ins.func == OP_STORE && mch == CH_MEM)
                r_mem[mar[MEM_AW-1:0]] <= r_regs[R_MDR];
            if (r_ins.func == OP_STORE && mch == CH_CST)
                r_stk[mar[STK_AW-1:0]] <= r_regs[R_MDR];
            if (r_ins.func == OP_CALL)
                r_stk[r_stk_len[STK_AW-1:0]] <= ip;
        end
    end

    // register file and stack length: control state, reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++)
                r_regs[i] <= (REG_AW'(i) == R_CSP) ? '1 : '0;
            r_stk_len <= '0;
        end else if (i_cmd.commit && r_st == ST_OK) begin
            case (r_ins.func)
                OP_PLACE: begin
                    if (r_ins.operand_b[REG_AW-1:0] == R_IP) begin
                        r_regs[R_IP] <= r_ins.operand_a + 64'd2;
                    end else begin
                        r_regs[r_ins.operand_b[REG_AW-1:0]] <= r_ins.operand_a;
                        r_regs[R_IP] <= ip + 64'd2;
                    end
                end
                OP_MOVE: begin
                    if (r_ins.operand_b[REG_AW-1:0] == R_IP) begin
                        r_regs[R_IP] <= r_regs[r_ins.operand_a[REG_AW-1:0]] + 64'd2;
                    end else begin
                        r_regs[r_ins.operand_b[REG_AW-1:0]] <=
                            r_regs[r_ins.operand_a[REG_AW-1:0]];
                        r_regs[R_IP] <= ip + 64'd2;
                    end
                end
                OP_LOAD: r_regs[R_MDR] <= (mch == CH_MEM) ? r_mem_q : r_stk_q;
                OP_STORE: ;
                OP_JMP:  r_regs[R_IP] <= r_ins.operand_a - 64'd1;
                OP_JSET: r_regs[R_IP] <= (acc != 64'd0) ? r_ins.operand_a - 64'd1
                                                         : ip + 64'd1;
                OP_JCLR: r_regs[R_IP] <= (acc == 64'd0) ? r_ins.operand_a - 64'd1
                                                         : ip + 64'd1;
                OP_CALL: begin
                    r_stk_len     <= r_stk_len + STK_LW'(1);
                    r_regs[R_CSP] <= 64'(r_stk_len);
                    r_regs[R_IP]  <= r_ins.operand_a - 64'd1;
                end
                OP_RET: begin
                    r_stk_len     <= csp[STK_LW-1:0];
                    r_regs[R_IP]  <= r_stk_q + 64'd1;
                    r_regs[R_CSP] <= csp - 64'd1;
                end
                default: r_regs[R_ACC] <= r_acc_new;
            endcase
        end
    end

    always_comb begin
        o_result.status       = r_st;
        o_result.next_pointer = ip;
        o_result.acc_value    = acc;
    end

    `AVM_ASSERT(a_stk_len_bound, i_clk, i_rst_n, r_stk_len <= STK_LW'(STACK_DEPTH), "stack length beyond depth")
    `AVM_ASSERT(a_ok_only_on_ok, i_clk, i_rst_n, (i_cmd.commit && r_st != ST_OK) |=> $stable(r_stk_len), "faulted transaction changed stack")
    `AVM_ASSERT(a_mul_len, i_clk, i_rst_n, (i_cmd.mul_step && r_mul_cnt == 2'd3) |=> i_cmd.commit, "multiply overran")
endmodule
